// ===== sv/tpt_svf_band_shelf_filter_defines.svh =====
// Assertion macros for the band-shelf filter.
`ifndef TPT_SVF_BAND_SHELF_FILTER_DEFINES_SVH
`define TPT_SVF_BAND_SHELF_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SVF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svf assertion failed");
`define SVF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svf assertion failed");
`else
`define SVF_ASSERT_IMP(lbl, ante, cons)
`define SVF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/tpt_svf_pkg.sv =====
// Shared types, constants and saturation helpers for the band-shelf filter.
package tpt_svf_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned A_W = 42;
  localparam int unsigned B_W = 33;
  localparam int unsigned DIG_W = 21;
  localparam int unsigned PROD_W = 55;
  localparam int unsigned ACC_W = 75;

  localparam logic [CFG_IDX_W-1:0] REG_G = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_R = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHELF = 2'd3;

  localparam logic [30:0] G_RESET = 31'd26843546;
  localparam logic [30:0] TWO_R_RESET = 31'd268435456;
  localparam logic [30:0] D_RESET = 31'd1073741824;
  localparam logic signed [31:0] SHELF_RESET = 32'sd0;

  localparam logic signed [47:0] S40_MAX = 48'sh007F_FFFF_FFFF;
  localparam logic signed [47:0] S40_MIN = 48'shFF80_0000_0000;
  localparam logic signed [47:0] S24_MAX = 48'sh0000_007F_FFFF;
  localparam logic signed [47:0] S24_MIN = 48'shFFFF_FF80_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HI,
    ST_LO,
    ST_WB
  } state_t;

  typedef enum logic [2:0] {
    OP_T,
    OP_V,
    OP_BP,
    OP_S2,
    OP_Y
  } op_t;

  typedef struct packed {
    logic mul_hi;
    logic mul_lo;
    logic wb;
    logic out_load;
    op_t  op;
  } ctrl_t;

  function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
    logic signed [39:0] r;
    if (v > S40_MAX) begin
      r = S40_MAX[39:0];
    end else if (v < S40_MIN) begin
      r = S40_MIN[39:0];
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > S24_MAX) begin
      r = S24_MAX[23:0];
    end else if (v < S24_MIN) begin
      r = S24_MIN[23:0];
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/tpt_svf_mul.sv =====
// Shared multiplier: 42x33 signed product in two 21-bit digit passes.
module tpt_svf_mul (
  input  logic                                  clk,
  input  logic                                  hi,
  input  logic                                  lo,
  input  logic signed [tpt_svf_pkg::A_W-1:0]    a,
  input  logic signed [tpt_svf_pkg::B_W-1:0]    b,
  output logic signed [tpt_svf_pkg::ACC_W-1:0]  acc
);

  logic signed [tpt_svf_pkg::DIG_W:0]    dig;
  logic signed [tpt_svf_pkg::PROD_W-1:0] prod;
  logic signed [tpt_svf_pkg::ACC_W-1:0]  prod_ext;
  logic signed [tpt_svf_pkg::ACC_W-1:0]  acc_r;
  logic signed [tpt_svf_pkg::ACC_W-1:0]  acc_nxt;

  // upper digit carries the sign, lower digit is unsigned
  always_comb begin
    if (hi) begin
      dig = {a[tpt_svf_pkg::A_W-1], a[tpt_svf_pkg::A_W-1:tpt_svf_pkg::DIG_W]};
    end else begin
      dig = {1'b0, a[tpt_svf_pkg::DIG_W-1:0]};
    end
  end

  assign prod = dig * b;
  assign prod_ext = {{(tpt_svf_pkg::ACC_W-tpt_svf_pkg::PROD_W){prod[tpt_svf_pkg::PROD_W-1]}},
                     prod};

  always_comb begin
    if (hi) begin
      acc_nxt = prod_ext;
    end else if (lo) begin
      acc_nxt = (acc_r <<< tpt_svf_pkg::DIG_W) + prod_ext;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== sv/tpt_svf_ctrl.sv =====
// Sequencer: steps the five products of one item through the shared multiplier.
module tpt_svf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 slot_free,
  output logic                 in_ready,
  output tpt_svf_pkg::ctrl_t   ctl
);

  tpt_svf_pkg::state_t state_r, state_nxt;
  tpt_svf_pkg::op_t    op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    case (state_r)
      tpt_svf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = tpt_svf_pkg::ST_HI;
          op_nxt = tpt_svf_pkg::OP_T;
        end
      end
      tpt_svf_pkg::ST_HI: state_nxt = tpt_svf_pkg::ST_LO;
      tpt_svf_pkg::ST_LO: state_nxt = tpt_svf_pkg::ST_WB;
      tpt_svf_pkg::ST_WB: begin
        case (op_r)
          tpt_svf_pkg::OP_T: begin
            op_nxt = tpt_svf_pkg::OP_V;
            state_nxt = tpt_svf_pkg::ST_HI;
          end
          tpt_svf_pkg::OP_V: begin
            op_nxt = tpt_svf_pkg::OP_BP;
            state_nxt = tpt_svf_pkg::ST_HI;
          end
          tpt_svf_pkg::OP_BP: begin
            op_nxt = tpt_svf_pkg::OP_S2;
            state_nxt = tpt_svf_pkg::ST_HI;
          end
          tpt_svf_pkg::OP_S2: begin
            op_nxt = tpt_svf_pkg::OP_Y;
            state_nxt = tpt_svf_pkg::ST_HI;
          end
          tpt_svf_pkg::OP_Y: begin
            // hold until the output slot is free
            if (slot_free) begin
              state_nxt = tpt_svf_pkg::ST_IDLE;
            end
          end
          default: state_nxt = tpt_svf_pkg::ST_IDLE;
        endcase
      end
      default: state_nxt = tpt_svf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl.mul_hi = 1'b0;
    ctl.mul_lo = 1'b0;
    ctl.wb = 1'b0;
    ctl.out_load = 1'b0;
    ctl.op = op_r;
    case (state_r)
      tpt_svf_pkg::ST_IDLE: in_ready = 1'b1;
      tpt_svf_pkg::ST_HI:   ctl.mul_hi = 1'b1;
      tpt_svf_pkg::ST_LO:   ctl.mul_lo = 1'b1;
      tpt_svf_pkg::ST_WB: begin
        ctl.wb = 1'b1;
        ctl.out_load = (op_r == tpt_svf_pkg::OP_Y) && slot_free;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpt_svf_pkg::ST_IDLE;
      op_r <= tpt_svf_pkg::OP_T;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
    end
  end

endmodule

// ===== sv/tpt_svf_band_shelf_filter.sv =====
// Band-shelf filter top level: TPT state-variable core on one shared multiplier.
// Items: a new input is accepted only after the previous result is loaded into
// the output register; the five products of each item run in turn on the
// single 22x33 multiplier, and the load waits for a free output slot.
// Reset (synchronous, active low) zeroes both integrator states, loads the
// coefficient defaults and empties the output register; no clearing pass.
`include "tpt_svf_band_shelf_filter_defines.svh"

module tpt_svf_band_shelf_filter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [23:0]                    in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [23:0]                    out_sample_out,
  input  logic                                  cfg_we,
  input  logic [tpt_svf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpt_svf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [30:0]               g_r, two_r_r, d_r;
  logic signed [31:0]        shelf_r;
  logic signed [23:0]        x_r;
  logic signed [39:0]        s1_r, s2_r, bp_r;
  logic signed [40:0]        w_r;
  logic signed [23:0]        out_r;
  logic                      out_valid_r;

  tpt_svf_pkg::ctrl_t                      ctl;
  logic                                    slot_free;
  logic                                    in_acc;
  logic signed [tpt_svf_pkg::A_W-1:0]      mul_a;
  logic signed [tpt_svf_pkg::B_W-1:0]      mul_b;
  logic signed [tpt_svf_pkg::ACC_W-1:0]    acc;

  logic signed [34:0]        t_w;
  logic signed [39:0]        sh28_w, bp_w, s1_new, s2_new;
  logic signed [40:0]        diff_w, sum_w, s2_sum;
  logic signed [41:0]        s1_diff;
  logic signed [23:0]        y_w;

  assign slot_free = !out_valid_r || out_ready;
  assign in_acc = in_valid && in_ready;

  tpt_svf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .slot_free (slot_free),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = {{18{x_r[23]}}, x_r};
    mul_b = {2'b00, two_r_r};
    case (ctl.op)
      tpt_svf_pkg::OP_T: begin
        mul_a = {{18{x_r[23]}}, x_r};
        mul_b = {2'b00, two_r_r};
      end
      tpt_svf_pkg::OP_V: begin
        mul_a = {w_r[40], w_r};
        mul_b = {2'b00, g_r};
      end
      tpt_svf_pkg::OP_BP: begin
        mul_a = {w_r[40], w_r};
        mul_b = {2'b00, d_r};
      end
      tpt_svf_pkg::OP_S2: begin
        mul_a = {bp_r[39], bp_r, 1'b0};
        mul_b = {2'b00, g_r};
      end
      tpt_svf_pkg::OP_Y: begin
        mul_a = {{2{bp_r[39]}}, bp_r};
        mul_b = {shelf_r[31], shelf_r};
      end
      default: begin
        mul_a = {{18{x_r[23]}}, x_r};
        mul_b = {2'b00, two_r_r};
      end
    endcase
  end

  tpt_svf_mul u_mul (
    .clk (clk),
    .hi  (ctl.mul_hi),
    .lo  (ctl.mul_lo),
    .a   (mul_a),
    .b   (mul_b),
    .acc (acc)
  );

  // writeback arithmetic; arithmetic shifts give the floor of each product
  assign t_w = acc[54:20];
  assign diff_w = {{6{t_w[34]}}, t_w} - {s2_r[39], s2_r};
  assign sh28_w = tpt_svf_pkg::sat40({acc[74], acc[74:28]});
  assign sum_w = {sh28_w[39], sh28_w} + {s1_r[39], s1_r};
  assign bp_w = tpt_svf_pkg::sat40({{3{acc[74]}}, acc[74:30]});
  assign s1_diff = {bp_r[39], bp_r, 1'b0} - {{2{s1_r[39]}}, s1_r};
  assign s1_new = tpt_svf_pkg::sat40({{6{s1_diff[41]}}, s1_diff});
  assign s2_sum = {sh28_w[39], sh28_w} + {s2_r[39], s2_r};
  assign s2_new = tpt_svf_pkg::sat40({{7{s2_sum[40]}}, s2_sum});
  assign y_w = tpt_svf_pkg::sat24({{24{x_r[23]}}, x_r} + {{9{acc[74]}}, acc[74:36]});

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_sample_in;
    end
    if (ctl.wb) begin
      case (ctl.op)
        tpt_svf_pkg::OP_T:  w_r <= diff_w;
        tpt_svf_pkg::OP_V:  w_r <= sum_w;
        tpt_svf_pkg::OP_BP: bp_r <= bp_w;
        default: w_r <= w_r;
      endcase
    end
    if (ctl.out_load) begin
      out_r <= y_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // advance s1 while the g*2bp product is under way
      if (ctl.mul_hi && (ctl.op == tpt_svf_pkg::OP_S2)) begin
        s1_r <= s1_new;
      end
      if (ctl.wb && (ctl.op == tpt_svf_pkg::OP_S2)) begin
        s2_r <= s2_new;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r <= tpt_svf_pkg::G_RESET;
      two_r_r <= tpt_svf_pkg::TWO_R_RESET;
      d_r <= tpt_svf_pkg::D_RESET;
      shelf_r <= tpt_svf_pkg::SHELF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tpt_svf_pkg::REG_G:     g_r <= cfg_wdata[30:0];
        tpt_svf_pkg::REG_TWO_R: two_r_r <= cfg_wdata[30:0];
        tpt_svf_pkg::REG_D:     d_r <= cfg_wdata[30:0];
        tpt_svf_pkg::REG_SHELF: shelf_r <= cfg_wdata;
        default: g_r <= g_r;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_sample_out = out_r;

  `SVF_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `SVF_ASSERT_NXT(a_load_sets_valid, ctl.out_load, out_valid)
  `SVF_ASSERT_NXT(a_state_idle_hold, in_ready, $stable(s1_r) && $stable(s2_r))

endmodule

// ===== dv/tpt_svf_band_shelf_filter_tb.sv =====
// Testbench for the band-shelf filter: random and directed samples, scoreboard check.
module tpt_svf_band_shelf_filter_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned NUM_PHASES = 8;

  // Golden filter: coefficient copies, integrator states and pending output samples.
  class shelf_scoreboard;
    localparam longint POS40 = (longint'(1) <<< 39) - 1;
    localparam longint NEG40 = -(longint'(1) <<< 39);
    localparam longint POS24 = (longint'(1) <<< 23) - 1;
    localparam longint NEG24 = -(longint'(1) <<< 23);

    logic [30:0]        g_coef;
    logic [30:0]        two_r_coef;
    logic [30:0]        d_coef;
    logic signed [31:0] shelf_coef;
    longint             integ_one;
    longint             integ_two;
    logic signed [23:0] expected_q[$];
    int                 errors;

    function void load_defaults();
      g_coef = tpt_svf_pkg::G_RESET;
      two_r_coef = tpt_svf_pkg::TWO_R_RESET;
      d_coef = tpt_svf_pkg::D_RESET;
      shelf_coef = tpt_svf_pkg::SHELF_RESET;
      integ_one = 0;
      integ_two = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [tpt_svf_pkg::CFG_IDX_W-1:0] idx,
                            logic [tpt_svf_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        tpt_svf_pkg::REG_G:     g_coef = val[30:0];
        tpt_svf_pkg::REG_TWO_R: two_r_coef = val[30:0];
        tpt_svf_pkg::REG_D:     d_coef = val[30:0];
        tpt_svf_pkg::REG_SHELF: shelf_coef = val;
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // floor(a*b / 2^sh), magnitude capped at 2^62
    function longint scaled_prod(longint a, longint b, int unsigned sh);
      logic         neg;
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] prod;
      logic [127:0] quo;
      logic         rem;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = ((b < 0) ? -b : b) & 64'hFFFF_FFFF;
      prod = 128'(ma) * 128'(mb);
      quo = prod >> sh;
      rem = (prod & ((128'd1 << sh) - 128'd1)) != 0;
      if (quo > (128'd1 << 62)) quo = 128'd1 << 62;
      if (neg) begin
        if (rem) quo = quo + 128'd1;
        return -longint'(quo[63:0]);
      end
      return longint'(quo[63:0]);
    endfunction

    function void note_input(logic signed [23:0] sample);
      longint x;
      longint t;
      longint v;
      longint bp;
      longint b2;
      longint v22;
      longint y;
      x = sample;
      t = scaled_prod(x, longint'(two_r_coef), 20);
      v = clamp(scaled_prod(t - integ_two, longint'(g_coef), 28), NEG40, POS40);
      bp = clamp(scaled_prod(v + integ_one, longint'(d_coef), 30), NEG40, POS40);
      b2 = bp + bp;
      integ_one = clamp(b2 - integ_one, NEG40, POS40);
      v22 = clamp(scaled_prod(b2, longint'(g_coef), 28), NEG40, POS40);
      integ_two = clamp(integ_two + v22, NEG40, POS40);
      y = clamp(x + scaled_prod(bp, longint'(shelf_coef), 36), NEG24, POS24);
      expected_q.push_back(y[23:0]);
    endfunction

    function void check_result(logic signed [23:0] actual);
      logic signed [23:0] exp_sample;
      if (expected_q.size() == 0) begin
        $error("sample_out: no result expected, actual %0d", actual);
        errors++;
        return;
      end
      exp_sample = expected_q.pop_front();
      if (exp_sample !== actual) begin
        $error("sample_out mismatch: expected %0d, actual %0d", exp_sample, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic signed [23:0]                    in_sample_in = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic signed [23:0]                    out_sample_out;
  logic                                  cfg_we = 1'b0;
  logic [tpt_svf_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [tpt_svf_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;

  shelf_scoreboard sb;
  int unsigned     send_idle_pct = 26;
  int unsigned     recv_idle_pct = 47;
  bit              hold_req = 1'b0;
  int unsigned     cycle_count = 0;

  tpt_svf_band_shelf_filter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: random back-pressure, plus a long hold-off on request.
  initial begin : out_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_sample_out);
  end

  task automatic send_sample(logic signed [23:0] sample);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_sample_in <= sample;
    do @(posedge clk); while (!in_ready);
    sb.note_input(sample);
  endtask

  // Drop valid so nothing is offered again, then wait for every result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Only call while the filter is idle; cfg_we stays high across the burst.
  task automatic write_coefs(logic [31:0] g, logic [31:0] two_r, logic [31:0] d,
                             logic [31:0] shelf);
    logic [31:0] vals[4];
    vals = '{g, two_r, d, shelf};
    foreach (vals[i]) begin
      cfg_we <= 1'b1;
      cfg_index <= tpt_svf_pkg::CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(tpt_svf_pkg::CFG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [23:0] pick_sample();
    logic signed [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 24'sh7F_FFFF;
          1: return 24'sh80_0000;
          2: return 24'sd0;
          default: return -24'sd1;
        endcase
      end
      1, 2, 3, 4: return r[23:0];
      default: return $signed(r[31:8]) >>> $urandom_range(22, 1);
    endcase
  endfunction

  // Musical settings, raw random settings or range extremes.
  task automatic pick_coefs(int unsigned mode);
    real g;
    real two_r;
    real shelf;
    logic [31:0] gq;
    logic [31:0] rq;
    logic [31:0] dq;
    logic [31:0] sq;
    case (mode)
      0: begin
        g = $urandom_range(3000, 1) / 1000.0;
        two_r = $urandom_range(4000, 50) / 1000.0;
        shelf = ($urandom_range(8000) / 1000.0) - 0.99;
        gq = $rtoi(g * 268435456.0);
        rq = $rtoi(two_r * 268435456.0);
        dq = $rtoi(1073741824.0 / (1.0 + two_r * g + g * g));
        sq = $rtoi(shelf * 268435456.0);
      end
      1: begin
        gq = $urandom;
        rq = $urandom;
        dq = $urandom;
        sq = $urandom;
      end
      default: begin
        gq = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h0;
        rq = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h0;
        dq = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h4000_0000;
        sq = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
    endcase
    write_coefs(gq, rq, dq, sq);
  endtask

  initial begin
    logic signed [23:0] corner[8];
    sb = new;
    sb.load_defaults();
    corner = '{24'sh7F_FFFF, 24'sh80_0000, 24'sd0, -24'sd1, 24'sd1,
               24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh80_0000};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default coefficients, then saturating and out-of-range settings.
    foreach (corner[i]) send_sample(corner[i]);
    wait_drained();
    write_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    foreach (corner[i]) send_sample(corner[i]);
    wait_drained();
    write_coefs(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    for (int i = 0; i < 4; i++) send_sample(corner[i]);
    wait_drained();
    write_coefs(32'h7FFF_FFFF, 32'h0, 32'h4000_0000, 32'h8000_0000);
    foreach (corner[i]) send_sample(corner[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p < 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 47;
      end else if (p < 6) begin
        send_idle_pct = 47;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick_coefs(p == 7 ? 2 : (p % 3 == 2 ? 1 : 0));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && (p == 1 || p == 6)) hold_req = 1'b1;
        send_sample(pick_sample());
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
